/* hw/rtl/lzbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS bit decompressor package
// Shared payload types, token phases, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lzbd_pkg;

    // Most results that one accepted input request may produce.
    localparam int unsigned MAX_RESULTS = 19;
    localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);

    // Output limit register.
    localparam int unsigned    LIMIT_W     = 32;
    localparam logic [31:0]    LIMIT_RESET = 32'hFFFF_FFFF;

    // One compressed input request.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    // One decoded result request.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       stream_end;
        logic       last_of_run;
    } out_item_t;

    // Which token field the bit reader expects next.
    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LIT,
        PH_POS,
        PH_LEN
    } phase_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_COPY,
        ST_FLUSH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // latch the accepted input request
        logic new_stream;  // return stream state to its reset values
        logic append;      // append the latched byte to the bit buffer
        logic take;        // consume the current token field
        logic match_rd;    // read one history byte of a match
        logic put_lit;     // emit the literal field and store it in history
        logic put_mem;     // emit the history byte read last and store it
        logic end_stream;  // emit the end-of-stream result
        logic flush;       // release the held result as the last of the run
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic   finished;
        logic   at_cap;
        logic   remain_nz;
        logic   need_ok;
        phase_t phase;
        logic   field_zero;
        logic   limit_hit;
        logic   emit_ok;
        logic   last_in;
    } sts_t;

endpackage

/* hw/rtl/lzbd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS bit decompressor controller
// Sequences one input request: resumes work left over from the previous
// request, feeds the new byte, decodes tokens and copies matches, and finally
// releases the last result of the run.
// ----------------------------------------------------------------------------
module lzbd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           comp_valid,
    output logic           comp_ready,
    input  lzbd_pkg::sts_t sts,
    output lzbd_pkg::cmd_t cmd
);

    lzbd_pkg::ctrl_state_t state_reg, state_next;
    logic                  fed_reg, fed_next;

    logic stop_fin;
    logic stop_cap;
    logic stop_bits;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzbd_pkg::ST_IDLE;
            fed_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fed_reg   <= fed_next;
        end
    end

    // Reasons for the decode loop to stop.
    assign stop_fin  = sts.finished;
    assign stop_cap  = !sts.finished && sts.at_cap;
    assign stop_bits = !sts.finished && !sts.at_cap && !sts.remain_nz && !sts.need_ok;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        fed_next   = fed_reg;
        cmd        = '0;
        comp_ready = 1'b0;
        case (state_reg)
            lzbd_pkg::ST_IDLE:
            begin
                comp_ready = 1'b1;
                if (comp_valid)
                begin
                    cmd.load   = 1'b1;
                    fed_next   = 1'b0;
                    state_next = lzbd_pkg::ST_RUN;
                end
            end
            lzbd_pkg::ST_RUN:
            begin
                if (sts.emit_ok)
                begin
                    if (stop_fin || stop_cap || stop_bits)
                    begin
                        // The loop stopped; decide what to do with the new byte.
                        if (fed_reg || stop_cap)
                        begin
                            state_next = lzbd_pkg::ST_FLUSH;
                        end
                        else if (stop_fin)
                        begin
                            cmd.new_stream = sts.last_in;
                            state_next     = lzbd_pkg::ST_FLUSH;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            fed_next   = 1'b1;
                        end
                    end
                    else if (sts.remain_nz)
                    begin
                        cmd.match_rd = 1'b1;
                        state_next   = lzbd_pkg::ST_COPY;
                    end
                    else
                    begin
                        cmd.take = 1'b1;
                        case (sts.phase)
                            lzbd_pkg::PH_LIT:
                            begin
                                if (sts.limit_hit)
                                begin
                                    cmd.end_stream = 1'b1;
                                end
                                else
                                begin
                                    cmd.put_lit = 1'b1;
                                end
                            end
                            lzbd_pkg::PH_POS:
                            begin
                                cmd.end_stream = sts.field_zero;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            lzbd_pkg::ST_COPY:
            begin
                // Emit the history byte that was just read, or end the stream at the output limit.
                if (sts.emit_ok)
                begin
                    if (sts.limit_hit)
                    begin
                        cmd.end_stream = 1'b1;
                    end
                    else
                    begin
                        cmd.put_mem = 1'b1;
                    end
                    state_next = lzbd_pkg::ST_RUN;
                end
            end
            lzbd_pkg::ST_FLUSH:
            begin
                if (sts.emit_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = lzbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lzbd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/lzbd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS bit decompressor datapath
// Bit buffer and field extraction, token state, history memory with a fill
// count, output limit, and a hold stage plus output register for results.
// ----------------------------------------------------------------------------
module lzbd_datapath #(
    parameter int POSITION_BITS = 13,
    parameter int LENGTH_BITS   = 4,
    parameter int MIN_MATCH     = 3,
    parameter int HISTORY_DEPTH = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lzbd_pkg::in_item_t            comp_item,
    input  logic                          cfg_valid,
    input  logic [lzbd_pkg::LIMIT_W-1:0]  cfg_data,
    input  logic                          dec_ready,
    output logic                          dec_valid,
    output lzbd_pkg::out_item_t           dec_item,
    input  lzbd_pkg::cmd_t                cmd,
    output lzbd_pkg::sts_t                sts
);

    // History depth is a power of two; positions wrap by truncation.
    localparam int AW       = $clog2(HISTORY_DEPTH);
    localparam int FW       = AW + 1;
    localparam int NEED_A   = (POSITION_BITS > 8) ? POSITION_BITS : 8;
    localparam int NEED_MAX = (LENGTH_BITS > NEED_A) ? LENGTH_BITS : NEED_A;
    localparam int BW       = NEED_MAX + 7;
    localparam int CW       = $clog2(BW + 1);
    localparam int RW       = $clog2((1 << LENGTH_BITS) + MIN_MATCH);
    localparam int RES_W    = lzbd_pkg::RES_W;

    // Stream state.
    logic [BW-1:0]                 bitbuf_reg, bitbuf_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    lzbd_pkg::phase_t              phase_reg, phase_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [AW-1:0]                 wp_reg, wp_next;
    logic [RW-1:0]                 remain_reg, remain_next;
    logic [lzbd_pkg::LIMIT_W-1:0]  emitted_reg, emitted_next;
    logic [lzbd_pkg::LIMIT_W-1:0]  limit_reg, limit_next;
    logic [FW-1:0]                 fill_reg, fill_next;
    logic                          finished_reg, finished_next;
    logic                          padding_reg, padding_next;
    logic [RES_W-1:0]              res_cnt_reg, res_cnt_next;
    logic [7:0]                    byte_reg, byte_next;
    logic                          last_reg, last_next;

    // Result staging.
    logic                          hold_valid_reg, hold_valid_next;
    lzbd_pkg::out_item_t           hold_reg, hold_next;
    logic                          out_valid_reg, out_valid_next;
    lzbd_pkg::out_item_t           out_reg, out_next;

    // History memory.
    logic [7:0]                    hist_mem [HISTORY_DEPTH];
    logic [7:0]                    rd_data_reg;
    logic                          rd_ok_reg;

    logic                          flag_bit;
    logic [7:0]                    lit_field;
    logic [POSITION_BITS-1:0]      pos_field;
    logic [LENGTH_BITS-1:0]        len_field;
    logic [CW-1:0]                 need;
    logic [BW-1:0]                 bitbuf_taken;
    logic [CW-1:0]                 cnt_taken;
    logic [BW-1:0]                 bitbuf_appended;
    logic [AW-1:0]                 rel_addr;
    logic                          rd_ok;
    logic [7:0]                    copy_byte;
    logic [7:0]                    put_value;
    logic                          write_en;
    logic                          emit;
    logic                          push;
    logic                          push_last;
    logic                          restart;

    // Fields sit at the top of the left-aligned bit buffer.
    assign flag_bit  = bitbuf_reg[BW-1];
    assign lit_field = bitbuf_reg[BW-1 -: 8];
    assign pos_field = bitbuf_reg[BW-1 -: POSITION_BITS];
    assign len_field = bitbuf_reg[BW-1 -: LENGTH_BITS];

    // Field width for the current phase and the buffer after consuming it.
    always_comb
    begin
        case (phase_reg)
            lzbd_pkg::PH_FLAG:
            begin
                need         = CW'(1);
                bitbuf_taken = bitbuf_reg << 1;
            end
            lzbd_pkg::PH_LIT:
            begin
                need         = CW'(8);
                bitbuf_taken = bitbuf_reg << 8;
            end
            lzbd_pkg::PH_POS:
            begin
                need         = CW'(POSITION_BITS);
                bitbuf_taken = bitbuf_reg << POSITION_BITS;
            end
            default:
            begin
                need         = CW'(LENGTH_BITS);
                bitbuf_taken = bitbuf_reg << LENGTH_BITS;
            end
        endcase
    end

    // In padding the missing low bits are already zero in the buffer.
    assign cnt_taken       = (cnt_reg > need) ? (cnt_reg - need) : '0;
    assign bitbuf_appended = bitbuf_reg | ({byte_reg, {(BW - 8){1'b0}}} >> cnt_reg);

    // An entry counts as written when it lies among the first fill_reg
    // positions starting at position one; others read as zero.
    assign rel_addr  = pos_reg - AW'(1);
    assign rd_ok     = {1'b0, rel_addr} < fill_reg;
    assign copy_byte = rd_ok_reg ? rd_data_reg : 8'h00;
    assign put_value = cmd.put_mem ? copy_byte : lit_field;
    assign write_en  = cmd.put_lit || cmd.put_mem;
    assign emit      = write_en || cmd.end_stream;
    assign push_last = cmd.flush && hold_valid_reg;
    assign push      = (emit && hold_valid_reg) || push_last;
    assign restart   = cmd.new_stream || (cmd.end_stream && padding_reg);

    // Next-state logic for the stream and configuration.
    always_comb
    begin
        bitbuf_next   = bitbuf_reg;
        cnt_next      = cnt_reg;
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        wp_next       = wp_reg;
        remain_next   = remain_reg;
        emitted_next  = emitted_reg;
        fill_next     = fill_reg;
        finished_next = finished_reg;
        padding_next  = padding_reg;
        res_cnt_next  = res_cnt_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        limit_next    = limit_reg;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        // Latch the accepted request.
        if (cmd.load)
        begin
            byte_next    = comp_item.in_byte;
            last_next    = comp_item.last_byte;
            res_cnt_next = '0;
        end

        // Feed the byte into the bit buffer.
        if (cmd.append)
        begin
            bitbuf_next  = bitbuf_appended;
            cnt_next     = cnt_reg + CW'(8);
            padding_next = last_reg;
        end

        // Consume one token field.
        if (cmd.take)
        begin
            bitbuf_next = bitbuf_taken;
            cnt_next    = cnt_taken;
            case (phase_reg)
                lzbd_pkg::PH_FLAG:
                begin
                    phase_next = flag_bit ? lzbd_pkg::PH_LIT : lzbd_pkg::PH_POS;
                end
                lzbd_pkg::PH_LIT:
                begin
                    phase_next = lzbd_pkg::PH_FLAG;
                end
                lzbd_pkg::PH_POS:
                begin
                    if (pos_field == '0)
                    begin
                        phase_next = lzbd_pkg::PH_FLAG;
                    end
                    else
                    begin
                        pos_next   = AW'(pos_field);
                        phase_next = lzbd_pkg::PH_LEN;
                    end
                end
                default:
                begin
                    remain_next = RW'(len_field) + RW'(MIN_MATCH);
                    phase_next  = lzbd_pkg::PH_FLAG;
                end
            endcase
        end

        // Step through a match.
        if (cmd.match_rd)
        begin
            pos_next    = pos_reg + AW'(1);
            remain_next = remain_reg - RW'(1);
        end

        // Every emitted byte goes into history.
        if (write_en)
        begin
            wp_next      = wp_reg + AW'(1);
            emitted_next = emitted_reg + 32'd1;
            if (fill_reg != FW'(HISTORY_DEPTH))
            begin
                fill_next = fill_reg + FW'(1);
            end
        end

        if (emit)
        begin
            res_cnt_next = res_cnt_reg + RES_W'(1);
        end

        // End of stream without padding parks the decoder.
        if (cmd.end_stream && !padding_reg)
        begin
            finished_next = 1'b1;
            remain_next   = '0;
            bitbuf_next   = '0;
            cnt_next      = '0;
            phase_next    = lzbd_pkg::PH_FLAG;
        end

        // Fresh stream: all stream state back to reset values.
        if (restart)
        begin
            bitbuf_next   = '0;
            cnt_next      = '0;
            phase_next    = lzbd_pkg::PH_FLAG;
            pos_next      = '0;
            wp_next       = AW'(1);
            remain_next   = '0;
            emitted_next  = '0;
            fill_next     = '0;
            finished_next = 1'b0;
            padding_next  = 1'b0;
        end
    end

    // Hold stage delays each result by one so its last-of-run bit is known.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (push)
        begin
            out_valid_next       = 1'b1;
            out_next             = hold_reg;
            out_next.last_of_run = push_last;
        end
        else if (dec_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (emit)
        begin
            hold_valid_next      = 1'b1;
            hold_next.out_byte   = write_en ? put_value : 8'h00;
            hold_next.byte_valid = write_en;
            hold_next.stream_end = cmd.end_stream;
            hold_next.last_of_run = 1'b0;
        end
        else if (cmd.flush)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitbuf_reg     <= '0;
            cnt_reg        <= '0;
            phase_reg      <= lzbd_pkg::PH_FLAG;
            pos_reg        <= '0;
            wp_reg         <= AW'(1);
            remain_reg     <= '0;
            emitted_reg    <= '0;
            limit_reg      <= lzbd_pkg::LIMIT_RESET;
            fill_reg       <= '0;
            finished_reg   <= 1'b0;
            padding_reg    <= 1'b0;
            res_cnt_reg    <= '0;
            byte_reg       <= '0;
            last_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            bitbuf_reg     <= bitbuf_next;
            cnt_reg        <= cnt_next;
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            wp_reg         <= wp_next;
            remain_reg     <= remain_next;
            emitted_reg    <= emitted_next;
            limit_reg      <= limit_next;
            fill_reg       <= fill_next;
            finished_reg   <= finished_next;
            padding_reg    <= padding_next;
            res_cnt_reg    <= res_cnt_next;
            byte_reg       <= byte_next;
            last_reg       <= last_next;
            hold_valid_reg <= hold_valid_next;
            hold_reg       <= hold_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            hist_mem[wp_reg] <= put_value;
        end
        if (cmd.match_rd)
        begin
            rd_data_reg <= hist_mem[pos_reg];
            rd_ok_reg   <= rd_ok;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.finished   = finished_reg;
        sts.at_cap     = res_cnt_reg >= RES_W'(lzbd_pkg::MAX_RESULTS);
        sts.remain_nz  = remain_reg != '0;
        sts.need_ok    = (cnt_reg >= need) || padding_reg;
        sts.phase      = phase_reg;
        sts.field_zero = pos_field == '0;
        sts.limit_hit  = emitted_reg >= limit_reg;
        sts.emit_ok    = !hold_valid_reg || !out_valid_reg || dec_ready;
        sts.last_in    = last_reg;
    end

    assign dec_valid = out_valid_reg;
    assign dec_item  = out_reg;

endmodule

/* hw/rtl/lzss_bit_decompressor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS bit decompressor
// Decodes an MSB-first bit stream of literal and absolute-position match
// tokens into bytes, keeping a history of everything it emits.
// ----------------------------------------------------------------------------
// Usage:
// Compressed bytes enter on the comp channel, one request per byte; last_byte
// marks the final byte of a stream, after which zero bits are read until the
// end token. Decoded results leave on the dec channel; stream_end flags the
// end token or the output limit, and last_of_run flags the final result that
// belongs to one input byte. The cfg channel writes the output limit and is
// always ready; write it only while the decoder is idle.
// The controller handles one byte at a time and takes no new byte until it
// is through with the last. Each byte copied by a match is read from the
// history in ST_RUN and written back and emitted in ST_COPY; the history
// has one write port and one registered read port.
// Reset clears all stream state; the history reads as zero through a fill
// count, so no clearing pass is needed. When the receiver stalls, the output
// register and one hold stage fill and decoding pauses until results drain.
// ----------------------------------------------------------------------------
module lzss_bit_decompressor #(
    parameter int POSITION_BITS = 13,
    parameter int LENGTH_BITS   = 4,
    parameter int MIN_MATCH     = 3,
    parameter int HISTORY_DEPTH = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          comp_valid,
    output logic                          comp_ready,
    input  lzbd_pkg::in_item_t            comp_item,
    output logic                          dec_valid,
    input  logic                          dec_ready,
    output lzbd_pkg::out_item_t           dec_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lzbd_pkg::LIMIT_W-1:0]  cfg_data
);

    lzbd_pkg::cmd_t cmd;
    lzbd_pkg::sts_t sts;

    // The limit register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencer.
    lzbd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .comp_valid (comp_valid),
        .comp_ready (comp_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Bit reader, history and result staging.
    lzbd_datapath #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS),
        .MIN_MATCH     (MIN_MATCH),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .comp_item (comp_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .dec_ready (dec_ready),
        .dec_valid (dec_valid),
        .dec_item  (dec_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* sim/tb_lzss_bit_decompressor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS bit decompressor testbench
// Builds compressed bit streams of literal, match and end tokens, sends them
// with random gaps against random output stalls, and checks every decoded
// result against a cycle-free model of the decoder kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_lzss_bit_decompressor;

    // Token format of the decoder.
    localparam int          POS_W        = 13;
    localparam int          LEN_W        = 4;
    localparam int          MIN_MATCH    = 3;
    localparam int          HIST_DEPTH   = 8192;
    localparam logic        FLAG_LITERAL = 1'b1;
    localparam logic        FLAG_MATCH   = 1'b0;
    localparam logic [12:0] END_POSITION = 13'd0;

    // Run control.
    localparam int unsigned RANDOM_ITEMS  = 170;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned STALL_LIMIT   = 2000;

    logic                          clk;
    logic                          rst_n;
    logic                          comp_valid;
    logic                          comp_ready;
    lzbd_pkg::in_item_t            comp_item;
    logic                          dec_valid;
    logic                          dec_ready;
    lzbd_pkg::out_item_t           dec_item;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [lzbd_pkg::LIMIT_W-1:0]  cfg_data;

    int unsigned         stall_count = 0;
    int unsigned         items_sent  = 0;
    bit                  stream_bits[$];

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the decoder state and the results still owed.
    // ------------------------------------------------------------------------
    class decode_scoreboard;
        logic [7:0]           hist [HIST_DEPTH];
        logic [12:0]          wr_ptr;
        logic [23:0]          bit_buf;
        logic [4:0]           bit_cnt;
        lzbd_pkg::phase_t     phase;
        logic [12:0]          match_pos;
        logic [4:0]           match_left;
        logic [31:0]          emitted;
        logic                 stream_done;
        logic                 in_padding;
        logic [31:0]          limit;
        int                   nres;
        bit                   carry_pending;
        lzbd_pkg::out_item_t  decoded_q[$];
        int unsigned          errors;
        int unsigned          bytes_seen;
        int unsigned          ends_seen;
        int unsigned          carries;

        function new();
            limit = lzbd_pkg::LIMIT_RESET;
            errors = 0;
            bytes_seen = 0;
            ends_seen = 0;
            carries = 0;
            carry_pending = 1'b0;
            start_stream();
        endfunction

        function void set_limit(logic [31:0] value);
            limit = value;
        endfunction

        // Everything a stream owns goes back to its reset value.
        function void start_stream();
            foreach (hist[i])
                hist[i] = 8'h00;
            wr_ptr      = 13'd1;
            bit_buf     = '0;
            bit_cnt     = '0;
            phase       = lzbd_pkg::PH_FLAG;
            match_pos   = '0;
            match_left  = '0;
            emitted     = '0;
            stream_done = 1'b0;
            in_padding  = 1'b0;
        endfunction

        function void push_result(logic [7:0] value, logic is_byte, logic is_end);
            lzbd_pkg::out_item_t r;
            r.out_byte    = value;
            r.byte_valid  = is_byte;
            r.stream_end  = is_end;
            r.last_of_run = 1'b0;
            decoded_q.push_back(r);
            nres++;
        endfunction

        // The end report; a stream that ends in its padding restarts at once.
        function void close_stream();
            push_result(8'h00, 1'b0, 1'b1);
            if (in_padding)
                start_stream();
            else
            begin
                stream_done = 1'b1;
                match_left  = '0;
                bit_buf     = '0;
                bit_cnt     = '0;
                phase       = lzbd_pkg::PH_FLAG;
            end
        endfunction

        // Each byte first checks the output limit, then goes to the history.
        function void emit_byte(logic [7:0] value);
            if (emitted >= limit)
            begin
                close_stream();
                return;
            end
            push_result(value, 1'b1, 1'b0);
            hist[wr_ptr] = value;
            wr_ptr = wr_ptr + 13'd1;
            emitted = emitted + 32'd1;
        endfunction

        function logic [12:0] take_bits(logic [4:0] k);
            logic [4:0]  sh;
            logic [23:0] field;
            sh = bit_cnt - k;
            field = (bit_buf >> sh) & ((24'd1 << k) - 24'd1);
            bit_cnt = sh;
            bit_buf = bit_buf & ((24'd1 << sh) - 24'd1);
            return field[12:0];
        endfunction

        // Decodes until bits run out or the stream has ended; returns 1 when stopped by the result cap.
        function bit decode_run();
            logic [4:0]  need;
            logic [12:0] fld;
            logic [7:0]  copied;
            while (1'b1)
            begin
                if (stream_done)
                    return 1'b0;
                if (nres >= lzbd_pkg::MAX_RESULTS)
                    return 1'b1;
                if (match_left != 0)
                begin
                    copied = hist[match_pos];
                    match_pos = match_pos + 13'd1;
                    match_left = match_left - 5'd1;
                    emit_byte(copied);
                    continue;
                end
                case (phase)
                    lzbd_pkg::PH_FLAG: need = 5'd1;
                    lzbd_pkg::PH_LIT:  need = 5'd8;
                    lzbd_pkg::PH_POS:  need = 5'(POS_W);
                    default:           need = 5'(LEN_W);
                endcase
                // Past the last byte, missing bits read as zero.
                if (bit_cnt < need)
                begin
                    if (!in_padding)
                        return 1'b0;
                    bit_buf = bit_buf << (need - bit_cnt);
                    bit_cnt = need;
                end
                fld = take_bits(need);
                case (phase)
                    lzbd_pkg::PH_FLAG:
                        phase = (fld[0] == FLAG_LITERAL) ? lzbd_pkg::PH_LIT
                                                         : lzbd_pkg::PH_POS;
                    lzbd_pkg::PH_LIT:
                    begin
                        phase = lzbd_pkg::PH_FLAG;
                        emit_byte(fld[7:0]);
                    end
                    lzbd_pkg::PH_POS:
                    begin
                        if (fld == END_POSITION)
                        begin
                            phase = lzbd_pkg::PH_FLAG;
                            close_stream();
                        end
                        else
                        begin
                            match_pos = fld;
                            phase = lzbd_pkg::PH_LEN;
                        end
                    end
                    default:
                    begin
                        match_left = 5'(fld[LEN_W-1:0]) + 5'(MIN_MATCH);
                        phase = lzbd_pkg::PH_FLAG;
                    end
                endcase
            end
            return 1'b0;
        endfunction

        // Notes one accepted input request and queues the results it causes.
        function void note_input(lzbd_pkg::in_item_t item);
            bit capped;
            nres = 0;
            capped = decode_run();
            if (!capped)
            begin
                if (stream_done)
                begin
                    // Bytes after the end are dropped until the last one.
                    if (item.last_byte)
                        start_stream();
                end
                else
                begin
                    bit_buf = {bit_buf[15:0], item.in_byte};
                    bit_cnt = bit_cnt + 5'd8;
                    in_padding = item.last_byte;
                    capped = decode_run();
                end
            end
            if (capped)
                carries++;
            carry_pending = capped;
            if (nres > 0)
                decoded_q[decoded_q.size() - 1].last_of_run = 1'b1;
        endfunction

        // Compares one accepted result request with the oldest one owed.
        function void check_result(lzbd_pkg::out_item_t got);
            lzbd_pkg::out_item_t want;
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual byte=%02h valid=%b end=%b last=%b",
                         $time, got.out_byte, got.byte_valid, got.stream_end,
                         got.last_of_run);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.stream_end !== want.stream_end || got.last_of_run !== want.last_of_run)
            begin
                $display("%0t: mismatch, expected byte=%02h valid=%b end=%b last=%b",
                         $time, want.out_byte, want.byte_valid, want.stream_end,
                         want.last_of_run);
                $display("%0t:           actual   byte=%02h valid=%b end=%b last=%b",
                         $time, got.out_byte, got.byte_valid, got.stream_end,
                         got.last_of_run);
                errors++;
            end
            if (want.byte_valid)
                bytes_seen++;
            if (want.stream_end)
                ends_seen++;
        endfunction
    endclass

    decode_scoreboard book;

    lzss_bit_decompressor u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .comp_valid (comp_valid),
        .comp_ready (comp_ready),
        .comp_item  (comp_item),
        .dec_valid  (dec_valid),
        .dec_ready  (dec_ready),
        .dec_item   (dec_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // The receiver stalls at random, with occasional long calm stretches.
    initial
    begin
        int unsigned run_len;
        int unsigned stall_len;
        dec_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 20);
            dec_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall_len = pick_gap();
            if (stall_len > 0)
            begin
                dec_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // Every accepted request is seen here, inputs before results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                book.set_limit(cfg_data);
            if (comp_valid && comp_ready)
                book.note_input(comp_item);
            if (dec_valid && dec_ready)
                book.check_result(dec_item);
            if ((cfg_valid && cfg_ready) || (comp_valid && comp_ready) ||
                (dec_valid && dec_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
        end
    end

    // Watchdog on cycles without any accepted request.
    initial
    begin
        wait (stall_count >= STALL_LIMIT);
        $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Sends one compressed byte after a random gap and waits for acceptance.
    task automatic send_byte(input logic [7:0] data, input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            comp_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        comp_valid <= 1'b1;
        comp_item  <= '{in_byte: data, last_byte: last};
        do
            @(posedge clk);
        while (!comp_ready);
        items_sent++;
    endtask

    task automatic put_bits(input logic [15:0] value, input int width);
        for (int i = width - 1; i >= 0; i--)
            stream_bits.push_back(value[i]);
    endtask

    task automatic put_literal(input logic [7:0] value);
        put_bits(16'(FLAG_LITERAL), 1);
        put_bits(16'(value), 8);
    endtask

    task automatic put_match(input logic [12:0] pos, input logic [3:0] len);
        put_bits(16'(FLAG_MATCH), 1);
        put_bits(16'(pos), POS_W);
        put_bits(16'(len), LEN_W);
    endtask

    task automatic put_end();
        put_bits(16'(FLAG_MATCH), 1);
        put_bits(16'(END_POSITION), POS_W);
    endtask

    // Packs the pending bits into bytes and sends them. Trailing zeros may be
    // trimmed, since the decoder reads zeros after the last byte anyway.
    task automatic send_bits(input bit mark_last, input bit trim);
        logic [7:0] data;
        if (trim)
            while (stream_bits.size() > 0 && stream_bits[$] == 1'b0)
                void'(stream_bits.pop_back());
        if (stream_bits.size() == 0)
            stream_bits.push_back(1'b0);
        while (stream_bits.size() > 0)
        begin
            data = '0;
            for (int i = 7; i >= 0; i--)
                if (stream_bits.size() > 0)
                    data[i] = stream_bits.pop_front();
            send_byte(data, mark_last && stream_bits.size() == 0);
        end
    endtask

    // Brings the decoder to rest: flushes results held past the cap, waits
    // for every owed result and then for the decoder's own latency.
    task automatic settle();
        comp_valid <= 1'b0;
        @(posedge clk);
        while (book.carry_pending)
        begin
            send_byte(8'h00, 1'b1);
            comp_valid <= 1'b0;
            @(posedge clk);
        end
        while (book.decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One random stream: mostly well formed, some noise, some junk after end.
    task automatic random_stream();
        int unsigned kind;
        int unsigned tokens;
        int unsigned produced;
        int unsigned nbytes;
        logic [12:0] pos;
        logic [3:0]  len;
        kind = $urandom_range(0, 9);
        if (kind >= 8)
        begin
            nbytes = $urandom_range(1, 6);
            repeat (nbytes)
                send_byte(8'($urandom()), ($urandom_range(0, 3) == 0));
            send_byte(8'($urandom()), 1'b1);
            return;
        end
        produced = 0;
        tokens = $urandom_range(1, 6);
        repeat (tokens)
        begin
            if (produced == 0 || $urandom_range(0, 2) != 0)
            begin
                put_literal(8'($urandom()));
                produced++;
            end
            else
            begin
                // Most matches point into bytes this stream has already made.
                if ($urandom_range(0, 3) != 0)
                    pos = 13'($urandom_range(1, (produced < HIST_DEPTH - 1) ?
                                                produced + 1 : HIST_DEPTH - 1));
                else
                    pos = 13'($urandom_range(1, HIST_DEPTH - 1));
                len = 4'($urandom_range(0, 15));
                put_match(pos, len);
                produced += len + MIN_MATCH;
            end
        end
        if (kind == 7)
        begin
            put_end();
            send_bits(1'b0, 1'b0);
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom()), 1'b0);
            send_byte(8'($urandom()), 1'b1);
        end
        else
        begin
            if ($urandom_range(0, 1) == 1)
                put_end();
            send_bits(1'b1, 1'($urandom_range(0, 1)));
        end
    endtask

    // Main sequence.
    initial
    begin
        int unsigned phase_end;
        book = new();
        rst_n      <= 1'b0;
        comp_valid <= 1'b0;
        comp_item  <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme literals, an overlapping match, a wrapping longest match and
        // an explicit end, followed by bytes that must be ignored.
        put_literal(8'h00);
        put_literal(8'hFF);
        put_match(13'd1, 4'd0);
        put_match(13'h1FFF, 4'hF);
        put_end();
        send_bits(1'b0, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);

        // A last byte that finishes a longest match and a literal holds more
        // results than one request may give; the next stream collects them.
        put_literal(8'h3C);
        put_match(13'd2, 4'hF);
        put_literal(8'h80);
        send_bits(1'b1, 1'b1);
        put_literal(8'h81);
        send_bits(1'b1, 1'b1);

        // A zero limit ends the stream at its first byte.
        write_limit(32'd0);
        put_literal(8'h11);
        put_literal(8'h22);
        send_bits(1'b1, 1'b0);

        // A small limit cuts a match short while in the padding.
        write_limit(32'd5);
        put_match(13'd1, 4'hF);
        send_bits(1'b1, 1'b1);

        // Random streams under several output limits.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       write_limit(lzbd_pkg::LIMIT_RESET);
                1:       write_limit(32'($urandom_range(1, 24)));
                2:       write_limit($urandom());
                default: write_limit(32'($urandom_range(25, 80)));
            endcase
            phase_end = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < phase_end)
                random_stream();
        end

        settle();
        $display("Sent %0d compressed bytes; checked %0d decoded bytes and %0d stream ends.",
                 items_sent, book.bytes_seen, book.ends_seen);
        $display("Limits from zero to all ones; %0d requests hit the result cap.",
                 book.carries);
        if (book.errors == 0 && book.decoded_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lzbd_pkg.sv
hw/rtl/lzbd_ctrl.sv
hw/rtl/lzbd_datapath.sv
hw/rtl/lzss_bit_decompressor.sv
sim/tb_lzss_bit_decompressor.sv
